### hw/rtl/rast_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rast_pkg: range add / range sum store, shared types and constants
// Widths, command and status codes, queue entry and back status structs.
// ----------------------------------------------------------------------------
package rast_pkg;

   localparam int MAX_POSITIONS = 1024;
   localparam int POS_W         = $clog2(MAX_POSITIONS);
   localparam int IDX_W         = POS_W + 1;
   localparam int CFG_W         = 11;
   localparam int DELTA_W       = 32;
   localparam int SUM_W         = 64;
   localparam int RAM_DEPTH     = 1 << POS_W;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_SUM    = 1'b1;
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef struct packed {
      logic                      cmd;
      logic [POS_W-1:0]          lo;
      logic [POS_W-1:0]          hi;
      logic signed [DELTA_W-1:0] delta;
      logic                      bad;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_stat_type;

endpackage

### hw/rtl/rast_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rast_if: channel interfaces
// Request and response channels with valid / ready handshake.
// ----------------------------------------------------------------------------
interface rast_req_if;
   logic                                valid;
   logic                                ready;
   logic                                cmd;
   logic [rast_pkg::POS_W-1:0]          range_low;
   logic [rast_pkg::POS_W-1:0]          range_high;
   logic signed [rast_pkg::DELTA_W-1:0] delta;

   modport source (output valid, cmd, range_low, range_high, delta, input ready);
   modport sink   (input valid, cmd, range_low, range_high, delta, output ready);
endinterface

interface rast_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [rast_pkg::SUM_W-1:0] range_sum;
   logic                              status;

   modport source (output valid, range_sum, status, input ready);
   modport sink   (input valid, range_sum, status, output ready);
endinterface

### hw/rtl/rast_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rast_ram: generic simple dual port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rast_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rast_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rast_front: request intake
// Holds the position count, checks each range and queues the transaction.
// ----------------------------------------------------------------------------
module rast_front (
   input  logic                       clock,
   input  logic                       reset,
   rast_req_if.sink                   req_ch,
   input  logic                       csr_wr_en,
   input  logic [rast_pkg::CFG_W-1:0] csr_wr_data,
   input  rast_pkg::back_stat_type    back_stat,
   output rast_pkg::head_type         head
);

   logic [rast_pkg::CFG_W-1:0] n_ff, n_in, n_eff;
   rast_pkg::item_type         q_ff [2];
   rast_pkg::item_type         new_item;
   logic                       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]                 cnt_ff, cnt_in;
   logic                       push;

   always_comb begin
      if (n_ff == '0) begin
         n_eff = rast_pkg::CFG_W'(1);
      end else if (n_ff > rast_pkg::CFG_W'(rast_pkg::MAX_POSITIONS)) begin
         n_eff = rast_pkg::CFG_W'(rast_pkg::MAX_POSITIONS);
      end else begin
         n_eff = n_ff;
      end
   end

   assign req_ch.ready = (cnt_ff != 2'd2) && !back_stat.clearing;
   assign push         = req_ch.valid && req_ch.ready;

   always_comb begin
      new_item.cmd   = req_ch.cmd;
      new_item.lo    = req_ch.range_low;
      new_item.hi    = req_ch.range_high;
      new_item.delta = req_ch.delta;
      new_item.bad   = (req_ch.range_low > req_ch.range_high) ||
                       ({{(rast_pkg::CFG_W-rast_pkg::POS_W){1'b0}}, req_ch.range_high}
                        >= n_eff);
   end

   always_comb begin
      n_in      = csr_wr_en ? csr_wr_data : n_ff;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ back_stat.pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, back_stat.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff      <= rast_pkg::CFG_W'(rast_pkg::MAX_POSITIONS);
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         n_ff      <= n_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

### hw/rtl/rast_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rast_back: execution sequencer
// Runs updates and prefix walks over two indexed-tree tables in ram,
// clears the tables after reset or a position count write.
// ----------------------------------------------------------------------------
module rast_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  rast_pkg::head_type      head,
   output rast_pkg::back_stat_type back_stat,
   rast_rsp_if.source              rsp_ch
);

   localparam int PW = rast_pkg::DELTA_W + rast_pkg::IDX_W + 1;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_UPD_RD, S_UPD_WR, S_QRY_RD, S_QRY_ACC, S_QRY_MUL, S_QRY_FIN
   } state_type;

   state_type                          state_ff, state_in;
   logic [rast_pkg::POS_W-1:0]         clr_ff, clr_in;
   logic [rast_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic                               phase_ff, phase_in;
   logic [rast_pkg::POS_W-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic signed [rast_pkg::DELTA_W-1:0] delta_ff, delta_in;
   logic [rast_pkg::SUM_W-1:0]         v1_ff, v1_in, v2_ff, v2_in;
   logic [rast_pkg::SUM_W-1:0]         s1_ff, s1_in, s2_ff, s2_in;
   logic [rast_pkg::SUM_W-1:0]         prod_ff, prod_in, acc_ff, acc_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rast_pkg::SUM_W-1:0]         sum_ff, sum_in;
   logic                               status_ff, status_in;

   logic [rast_pkg::IDX_W-1:0]          lowbit, idx_dn, mul_b, qi;
   logic [rast_pkg::IDX_W:0]            idx_up, hi_p2;
   logic signed [rast_pkg::DELTA_W-1:0] mul_d;
   logic signed [PW-1:0]                dprod;
   logic [rast_pkg::SUM_W-1:0]          dprod_ext, dext, pre;
   logic [rast_pkg::SUM_W-1:0]          rd1, rd2, wd1, wd2;
   logic [rast_pkg::POS_W-1:0]          wr_addr;
   logic                                wr_en, pop;

   assign lowbit = idx_ff & (~idx_ff + 1'b1);
   assign idx_up = {1'b0, idx_ff} + {1'b0, lowbit};
   assign idx_dn = idx_ff - lowbit;
   assign hi_p2  = {2'b00, hi_ff} + (rast_pkg::IDX_W+1)'(2);

   // shared delta by position multiplier
   assign mul_d     = (state_ff == S_IDLE) ? head.item.delta : delta_ff;
   assign mul_b     = (state_ff == S_IDLE) ? {1'b0, head.item.lo}
                                           : {1'b0, hi_ff} + 1'b1;
   assign dprod     = mul_d * $signed({1'b0, mul_b});
   assign dprod_ext = {{(rast_pkg::SUM_W-PW){dprod[PW-1]}}, dprod};
   assign dext      = {{(rast_pkg::SUM_W-rast_pkg::DELTA_W){mul_d[rast_pkg::DELTA_W-1]}},
                       mul_d};

   assign qi  = phase_ff ? {1'b0, lo_ff} : {1'b0, hi_ff} + 1'b1;
   assign pre = prod_ff - s2_ff;

   assign pop = (state_ff == S_IDLE) && head.valid && !rsp_valid_ff && !csr_wr_en;

   assign wr_en   = (state_ff == S_CLEAR) || (state_ff == S_UPD_WR);
   assign wr_addr = (state_ff == S_CLEAR) ? clr_ff : idx_ff[rast_pkg::POS_W-1:0];
   assign wd1     = (state_ff == S_CLEAR) ? '0 : rd1 + v1_ff;
   assign wd2     = (state_ff == S_CLEAR) ? '0 : rd2 + v2_ff;

   rast_ram #(.WIDTH(rast_pkg::SUM_W), .DEPTH(rast_pkg::RAM_DEPTH)) u_ram_lin (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wd1),
      .rd_addr (idx_ff[rast_pkg::POS_W-1:0]),
      .rd_data (rd1)
   );

   rast_ram #(.WIDTH(rast_pkg::SUM_W), .DEPTH(rast_pkg::RAM_DEPTH)) u_ram_ofs (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wd2),
      .rd_addr (idx_ff[rast_pkg::POS_W-1:0]),
      .rd_data (rd2)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      delta_in     = delta_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (pop) begin
               lo_in    = head.item.lo;
               hi_in    = head.item.hi;
               delta_in = head.item.delta;
               phase_in = 1'b0;
               if (head.item.bad) begin
                  rsp_valid_in = 1'b1;
                  sum_in       = '0;
                  status_in    = rast_pkg::STATUS_BAD;
               end else if (head.item.cmd == rast_pkg::CMD_ADD) begin
                  idx_in   = {1'b0, head.item.lo} + 1'b1;
                  v1_in    = dext;
                  v2_in    = dprod_ext;
                  state_in = S_UPD_RD;
               end else begin
                  idx_in   = {1'b0, head.item.hi} + 1'b1;
                  s1_in    = '0;
                  s2_in    = '0;
                  state_in = S_QRY_RD;
               end
            end
         end
         S_UPD_RD: begin
            state_in = S_UPD_WR;
         end
         S_UPD_WR: begin
            if (idx_up <= (rast_pkg::IDX_W+1)'(rast_pkg::MAX_POSITIONS)) begin
               idx_in   = idx_up[rast_pkg::IDX_W-1:0];
               state_in = S_UPD_RD;
            end else if (!phase_ff &&
                         hi_p2 <= (rast_pkg::IDX_W+1)'(rast_pkg::MAX_POSITIONS)) begin
               phase_in = 1'b1;
               idx_in   = hi_p2[rast_pkg::IDX_W-1:0];
               v1_in    = '0 - dext;
               v2_in    = '0 - dprod_ext;
               state_in = S_UPD_RD;
            end else begin
               rsp_valid_in = 1'b1;
               sum_in       = '0;
               status_in    = rast_pkg::STATUS_OK;
               state_in     = S_IDLE;
            end
         end
         S_QRY_RD: begin
            state_in = S_QRY_ACC;
         end
         S_QRY_ACC: begin
            s1_in  = s1_ff + rd1;
            s2_in  = s2_ff + rd2;
            idx_in = idx_dn;
            state_in = (idx_dn == '0) ? S_QRY_MUL : S_QRY_RD;
         end
         S_QRY_MUL: begin
            prod_in  = s1_ff * rast_pkg::SUM_W'(qi);
            state_in = S_QRY_FIN;
         end
         S_QRY_FIN: begin
            if (!phase_ff && lo_ff != '0) begin
               acc_in   = pre;
               phase_in = 1'b1;
               idx_in   = {1'b0, lo_ff};
               s1_in    = '0;
               s2_in    = '0;
               state_in = S_QRY_RD;
            end else begin
               rsp_valid_in = 1'b1;
               sum_in       = phase_ff ? acc_ff - pre : pre;
               status_in    = rast_pkg::STATUS_OK;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      if (csr_wr_en) begin
         state_in = S_CLEAR;
         clr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      phase_ff  <= phase_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      delta_ff  <= delta_in;
      v1_ff     <= v1_in;
      v2_ff     <= v2_in;
      s1_ff     <= s1_in;
      s2_ff     <= s2_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      sum_ff    <= sum_in;
      status_ff <= status_in;
   end

   assign back_stat.pop      = pop;
   assign back_stat.clearing = (state_ff == S_CLEAR);

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.range_sum = sum_ff;
   assign rsp_ch.status    = status_ff;

endmodule

### hw/rtl/range_add_range_sum_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_sum_tree: range add / range sum store
// Signed 64-bit array with range add and range sum, held as two indexed
// prefix trees in ram; intake and execution joined by a two entry queue.
//
//  channel  | dir | handshake        | contents
//  req_ch   | in  | valid / ready    | cmd, range_low, range_high, delta
//  rsp_ch   | out | valid / ready    | range_sum, status
//  csr      | in  | csr_wr_en        | positions in use (11 bits)
//
// a range add does one read-modify-write of the table rams per tree step over
// its two index walks; a query reads both tables per tree step for each of its
// two prefixes, then multiplies and combines the sums.
// after reset and after each csr write a clearing pass runs over all 1024
// table entries, during which no transaction is accepted. a bad range is
// answered in the cycle after it is taken from the queue.
// a waiting response does not block intake of up to two transactions.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree (
   input  logic                       clock,
   input  logic                       reset,
   rast_req_if.sink                   req_ch,
   rast_rsp_if.source                 rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [rast_pkg::CFG_W-1:0] csr_wr_data
);

   rast_pkg::head_type      head;
   rast_pkg::back_stat_type back_stat;

   rast_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .back_stat   (back_stat),
      .head        (head)
   );

   rast_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .head      (head),
      .back_stat (back_stat),
      .rsp_ch    (rsp_ch)
   );

   a_pop_has_head : assert property (@(posedge clock) disable iff (reset)
      back_stat.pop |-> head.valid)
      else $error("pop from empty queue");

   a_csr_clears : assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> back_stat.clearing)
      else $error("no clearing pass after csr write");

   a_bad_answer : assert property (@(posedge clock) disable iff (reset)
      back_stat.pop && head.item.bad |=>
         rsp_ch.valid && rsp_ch.status == rast_pkg::STATUS_BAD)
      else $error("bad range not flagged");

endmodule

### tb/rast_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rast_tb_if: testbench channel notes
// The channel interfaces come with the block; this file only holds the
// transaction and response records that the testbench queues use.
// ----------------------------------------------------------------------------
package rast_tb_pkg;

   typedef struct packed {
      logic                                cmd;
      logic [rast_pkg::POS_W-1:0]          lo;
      logic [rast_pkg::POS_W-1:0]          hi;
      logic signed [rast_pkg::DELTA_W-1:0] delta;
   } req_rec_type;

   typedef struct packed {
      logic signed [rast_pkg::SUM_W-1:0] range_sum;
      logic                              status;
   } rsp_rec_type;
endpackage

### tb/range_add_range_sum_tree_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_tb: self-checking bench for the range add / sum store
// Drives range adds and sum queries, idling both channels at random outside
// quiet runs; predicts each response from a flat array model, checks each field.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_tb;

   localparam int LIMIT = 3_000_000;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [rast_pkg::CFG_W-1:0] csr_wr_data;

   rast_req_if req_ch ();
   rast_rsp_if rsp_ch ();

   range_add_range_sum_tree dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [rast_pkg::SUM_W-1:0] cells [rast_pkg::MAX_POSITIONS];
   int                         n_pos;
   rast_tb_pkg::req_rec_type   pending_q [$];
   rast_tb_pkg::rsp_rec_type   expected_q [$];
   int                         errors = 0;
   int                         cycles = 0;
   int                         n_adds = 0, n_sums = 0, n_bad = 0;
   bit                         quiet = 1'b0;
   int                         drv_gap = 0, rcv_gap = 0;
   bit                         req_fire = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout at %0t", $time);
         $display("Verification failed");
         $finish;
      end
   end

   // request acceptance seen at the rising edge
   always @(posedge clock) begin
      req_fire <= req_ch.valid && req_ch.ready;
   end

   function automatic void store_clear(input int n);
      for (int i = 0; i < rast_pkg::MAX_POSITIONS; i++) cells[i] = '0;
      if (n == 0) n_pos = 1;
      else if (n > rast_pkg::MAX_POSITIONS) n_pos = rast_pkg::MAX_POSITIONS;
      else n_pos = n;
   endfunction

   function automatic rast_tb_pkg::rsp_rec_type store_apply(
      input rast_tb_pkg::req_rec_type r);
      rast_tb_pkg::rsp_rec_type   res;
      logic [rast_pkg::SUM_W-1:0] add;
      res = '0;
      add = {{(rast_pkg::SUM_W-rast_pkg::DELTA_W){r.delta[rast_pkg::DELTA_W-1]}},
             r.delta};
      if (r.lo > r.hi || int'(r.hi) >= n_pos) begin
         res.status = rast_pkg::STATUS_BAD;
         n_bad++;
      end else if (r.cmd == rast_pkg::CMD_ADD) begin
         for (int i = r.lo; i <= r.hi; i++) cells[i] += add;
         n_adds++;
      end else begin
         for (int i = r.lo; i <= r.hi; i++) res.range_sum += cells[i];
         n_sums++;
      end
      return res;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.cmd        <= 1'b0;
         req_ch.range_low  <= '0;
         req_ch.range_high <= '0;
         req_ch.delta      <= '0;
         drv_gap           <= 0;
      end else if (req_ch.valid && !req_fire) begin
         req_ch.valid <= 1'b1;
      end else if (drv_gap > 0) begin
         drv_gap <= drv_gap - 1;
         req_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
         rast_tb_pkg::req_rec_type r;
         r = pending_q.pop_front();
         expected_q.push_back(store_apply(r));
         req_ch.valid      <= 1'b1;
         req_ch.cmd        <= r.cmd;
         req_ch.range_low  <= r.lo;
         req_ch.range_high <= r.hi;
         req_ch.delta      <= r.delta;
         if (!quiet && $urandom_range(0, 4) == 0) drv_gap <= $urandom_range(1, 6);
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_ch.ready <= 1'b1;
      end else if (rcv_gap > 0) begin
         rcv_gap <= rcv_gap - 1;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rcv_gap <= $urandom_range(0, 5);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t unexpected response sum=%0d status=%0b", $time,
                     rsp_ch.range_sum, rsp_ch.status);
            errors++;
         end else begin
            rast_tb_pkg::rsp_rec_type e;
            e = expected_q.pop_front();
            if (e.range_sum !== rsp_ch.range_sum)
               $display("%0t range_sum expected %0d actual %0d", $time,
                        e.range_sum, rsp_ch.range_sum);
            if (e.status !== rsp_ch.status)
               $display("%0t status expected %0b actual %0b", $time,
                        e.status, rsp_ch.status);
            if (e.range_sum !== rsp_ch.range_sum || e.status !== rsp_ch.status)
               errors++;
         end
      end
   end

   function automatic rast_tb_pkg::req_rec_type mk(input logic c, input int lo,
                                                   input int hi, input logic [31:0] d);
      rast_tb_pkg::req_rec_type r;
      r.cmd = c;
      r.lo = lo[rast_pkg::POS_W-1:0];
      r.hi = hi[rast_pkg::POS_W-1:0];
      r.delta = d;
      return r;
   endfunction

   function automatic logic [31:0] rand_delta();
      case ($urandom_range(0, 4))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 20) - 10;
         default: return $urandom;
      endcase
   endfunction

   function automatic rast_tb_pkg::req_rec_type rand_item();
      int lo, hi;
      logic c;
      c = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
         lo = $urandom_range(0, 1023);
         hi = $urandom_range(0, 1023);
      end else begin
         lo = $urandom_range(0, n_pos - 1);
         hi = $urandom_range(0, 3) == 0 ? lo : $urandom_range(lo, n_pos - 1);
      end
      return mk(c, lo, hi, rand_delta());
   endfunction

   task automatic drain();
      while (pending_q.size() > 0 || expected_q.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(input int v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v[rast_pkg::CFG_W-1:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      store_clear(v);
   endtask

   initial begin
      int settings [6] = '{1, 2, 37, 0, 2047, 1000};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      store_clear(1024);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      pending_q.push_back(mk(rast_pkg::CMD_SUM, 0, 1023, 0));
      pending_q.push_back(mk(rast_pkg::CMD_ADD, 0, 1023, 32'h7FFF_FFFF));
      pending_q.push_back(mk(rast_pkg::CMD_ADD, 0, 1023, 32'h7FFF_FFFF));
      pending_q.push_back(mk(rast_pkg::CMD_SUM, 0, 1023, 0));
      pending_q.push_back(mk(rast_pkg::CMD_ADD, 1023, 1023, 32'h8000_0000));
      pending_q.push_back(mk(rast_pkg::CMD_ADD, 0, 0, 32'hFFFF_FFFF));
      pending_q.push_back(mk(rast_pkg::CMD_ADD, 341, 682, 32'h5555_AAAA));
      pending_q.push_back(mk(rast_pkg::CMD_SUM, 1023, 1023, 0));
      pending_q.push_back(mk(rast_pkg::CMD_SUM, 0, 0, 0));
      pending_q.push_back(mk(rast_pkg::CMD_SUM, 300, 700, 32'hFFFF_FFFF));
      pending_q.push_back(mk(rast_pkg::CMD_SUM, 5, 4, 0));
      pending_q.push_back(mk(rast_pkg::CMD_ADD, 1023, 0, 32'h1234_5678));
      pending_q.push_back(mk(rast_pkg::CMD_ADD, 512, 511, 32'h8000_0000));
      pending_q.push_back(mk(rast_pkg::CMD_SUM, 0, 1023, 0));
      drain();

      foreach (settings[k]) begin
         csr_write(settings[k]);
         pending_q.push_back(mk(rast_pkg::CMD_ADD, 0, n_pos - 1, rand_delta()));
         pending_q.push_back(mk(rast_pkg::CMD_SUM, n_pos - 1, n_pos - 1, 0));
         pending_q.push_back(mk(rast_pkg::CMD_SUM, 0, n_pos < 1024 ? n_pos : 1023, 0));
         for (int i = 0; i < 80; i++) pending_q.push_back(rand_item());
         if (k == 5) quiet = 1'b1;
         drain();
      end

      csr_write(1024);
      for (int i = 0; i < 40; i++) pending_q.push_back(rand_item());
      drain();

      $display("covered %0d adds, %0d sums, %0d bad ranges over several sizes",
               n_adds, n_sums, n_bad);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
